FILE: rtl/core/dmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmr_pkg: shared constants for the decimal mantissa rescaler
// Widths, round mode codes and the reciprocal used by the divide-by-ten unit.
// ----------------------------------------------------------------------------
package dmr_pkg;

	localparam int MANT_WORDS_DEF = 7;   // default mantissa width in 32-bit words
	localparam int IN_WORDS       = 7;   // mantissa words on the ports
	localparam int WORD_W         = 32;
	localparam int HALF_W         = 16;  // width of one chunk in the shared unit
	localparam int DIG_W          = 4;   // carry / remainder digit width
	localparam int SCALE_W        = 6;
	localparam int RND_W          = 2;
	localparam int ADDR_W         = 3;

	// Round mode codes
	localparam logic [RND_W-1:0] RM_TRUNC     = 2'd0;
	localparam logic [RND_W-1:0] RM_HALF_UP   = 2'd1;
	localparam logic [RND_W-1:0] RM_HALF_EVEN = 2'd2;

	// Register indexes
	localparam logic REG_ROUND_MODE = 1'b0;

	// Decimal constants
	localparam logic [DIG_W-1:0] TEN  = 4'd10;
	localparam logic [DIG_W-1:0] ONE  = 4'd1;
	localparam logic [DIG_W-1:0] HALF = 4'd5;

	// floor(2^23 / 10): quotient estimate is exact or one low for a 20-bit dividend
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 23;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838860;

endpackage : dmr_pkg
`default_nettype wire

FILE: rtl/core/decimal_mantissa_rescale.sv
`timescale 1ns / 1ps
`default_nettype none
// Work: no digit pass when the scales are equal, else d digit passes over all 2*MANT_WORDS
//   16-bit chunks in the shared multiply/divide unit, plus one increment pass when a
//   rounding increment is needed (d = |target_scale - source_scale|).
// Flow: a beat is taken once the last item is done, also while a result waits in the
//   output register. Reset (arst_n low) clears control state and sets round_mode to half up.
// ----------------------------------------------------------------------------
// decimal_mantissa_rescale: decimal scale adjust with rounding
// Multiplies or divides a wide unsigned mantissa by ten once per digit of scale
// difference, 16 bits per cycle through one shared unit, and rounds once at the end of a divide.
// ----------------------------------------------------------------------------
module decimal_mantissa_rescale #(
	parameter int MANT_WORDS = dmr_pkg::MANT_WORDS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// APB-style configuration port
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [dmr_pkg::ADDR_W-1:0]        paddr,
	input  wire  [dmr_pkg::WORD_W-1:0]        pwdata,
	output logic [dmr_pkg::WORD_W-1:0]        prdata,
	output logic                              pready,
	// input channel
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_0,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_1,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_2,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_3,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_4,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_5,
	input  wire  [dmr_pkg::WORD_W-1:0]        mant_word_6,
	input  wire  [dmr_pkg::SCALE_W-1:0]       source_scale,
	input  wire  [dmr_pkg::SCALE_W-1:0]       target_scale,
	input  wire                               sign_in,
	// output channel
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_0,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_1,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_2,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_3,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_4,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_5,
	output logic [dmr_pkg::WORD_W-1:0]        res_word_6,
	output logic [dmr_pkg::SCALE_W-1:0]       result_scale,
	output logic                              sign_out,
	output logic                              overflow
);

	// Number of 16-bit chunks that the shared unit walks per digit pass
	localparam int NH    = 2 * MANT_WORDS;
	localparam int IDX_W = $clog2(NH);
	localparam int HW    = dmr_pkg::HALF_W;
	localparam int DW    = dmr_pkg::DIG_W;
	localparam int MW    = HW + DW;                          // 20-bit unit operand
	localparam int PW    = MW + dmr_pkg::RECIP_W;            // reciprocal product
	localparam int IW    = dmr_pkg::IN_WORDS;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NH - 1);

	// Sequencer state codes
	localparam logic [1:0] S_IDLE = 2'd0;   // wait for an input beat
	localparam logic [1:0] S_RUN  = 2'd1;   // digit passes, multiply or divide
	localparam logic [1:0] S_RND  = 2'd2;   // increment pass after rounding up
	localparam logic [1:0] S_FIN  = 2'd3;   // hand the result to the output register

	logic [1:0]                    state_q;
	logic                          up_q;        // 1: scale up (multiply), 0: scale down
	logic [dmr_pkg::SCALE_W-1:0]   dig_q;       // digit passes left
	logic [IDX_W-1:0]              idx_q;       // chunk position within a pass
	logic [DW-1:0]                 carry_q;     // carry digit, remainder, or increment carry
	logic [DW-1:0]                 last_q;      // remainder of the latest finished pass
	logic                          sticky_q;    // any earlier discarded digit nonzero
	logic                          ovf_q;
	logic [dmr_pkg::SCALE_W-1:0]   dst_q;
	logic                          sign_q;
	logic [dmr_pkg::RND_W-1:0]     round_mode_q;
	logic [HW-1:0]                 m_q [NH];    // working mantissa, chunk 0 lowest

	// Output register
	logic                          out_valid_q;
	logic [dmr_pkg::WORD_W-1:0]    res_q [IW];
	logic [dmr_pkg::SCALE_W-1:0]   res_scale_q;
	logic                          res_sign_q;
	logic                          res_ovf_q;

	// ------------------------------------------------------------------------
	// Configuration port: one register, round_mode, at byte address 0.
	// ------------------------------------------------------------------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= dmr_pkg::RM_HALF_UP;
		end else if (cfg_wr && (paddr[2] == dmr_pkg::REG_ROUND_MODE)) begin
			round_mode_q <= pwdata[dmr_pkg::RND_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == dmr_pkg::REG_ROUND_MODE) begin
			prdata = {{(dmr_pkg::WORD_W - dmr_pkg::RND_W){1'b0}}, round_mode_q};
		end
	end

	// ------------------------------------------------------------------------
	// Input unpacking: split the port words into 16-bit chunks. Words at or
	// above MANT_WORDS are ignored; a wide mantissa starts with zero top words.
	// ------------------------------------------------------------------------
	logic [dmr_pkg::WORD_W-1:0] in_words [IW];
	logic [HW-1:0]              load_h   [NH];

	assign in_words[0] = mant_word_0;
	assign in_words[1] = mant_word_1;
	assign in_words[2] = mant_word_2;
	assign in_words[3] = mant_word_3;
	assign in_words[4] = mant_word_4;
	assign in_words[5] = mant_word_5;
	assign in_words[6] = mant_word_6;

	for (genvar j = 0; j < NH; j++) begin : g_load
		if ((j / 2) < IW) begin : g_port
			assign load_h[j] = in_words[j / 2][HW*(j % 2) +: HW];
		end else begin : g_zero
			assign load_h[j] = '0;
		end
	end

	// ------------------------------------------------------------------------
	// Shared unit. Multiply path: chunk * factor + carry (factor ten for a
	// digit pass, one for the increment pass). Divide path: {rem, chunk} / 10
	// by reciprocal estimate and one correction step.
	// ------------------------------------------------------------------------
	logic [DW-1:0]  fac;
	logic [MW-1:0]  mac;
	logic [MW-1:0]  dx;
	logic [PW-1:0]  rp;
	logic [HW:0]    q_est;
	logic [4:0]     ten_lo;
	logic [4:0]     r_est;
	logic [HW-1:0]  div_q;
	logic [DW-1:0]  div_r;
	logic           last_step;

	assign fac = (state_q == S_RND) ? dmr_pkg::ONE : dmr_pkg::TEN;
	assign mac = ({{DW{1'b0}}, m_q[0]} * {{HW{1'b0}}, fac}) + {{HW{1'b0}}, carry_q};

	assign dx     = {carry_q, m_q[NH-1]};
	assign rp     = {{dmr_pkg::RECIP_W{1'b0}}, dx} * {{MW{1'b0}}, dmr_pkg::RECIP_TEN};
	assign q_est  = rp[dmr_pkg::RECIP_SHIFT +: (HW + 1)];
	// low five bits of 10 * q_est are enough: the true remainder is below 20
	assign ten_lo = {q_est[3:0], 1'b0} + {q_est[1:0], 3'b000};
	assign r_est  = dx[4:0] - ten_lo;

	always_comb begin
		if (r_est >= 5'd10) begin
			div_q = q_est[HW-1:0] + HW'(1);
			div_r = DW'(r_est - 5'd10);
		end else begin
			div_q = q_est[HW-1:0];
			div_r = r_est[DW-1:0];
		end
	end

	assign last_step = (idx_q == IDX_LAST);

	// Rounding decision at the end of the last divide pass
	logic sticky_n;
	logic rnd_up;

	assign sticky_n = sticky_q || (last_q != '0);

	always_comb begin
		case (round_mode_q)
			dmr_pkg::RM_HALF_UP: begin
				rnd_up = (div_r >= dmr_pkg::HALF);
			end
			dmr_pkg::RM_HALF_EVEN: begin
				rnd_up = (div_r > dmr_pkg::HALF) ||
				         ((div_r == dmr_pkg::HALF) && (sticky_n || div_q[0]));
			end
			default: begin
				rnd_up = 1'b0;   // truncate, and the unused code
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	logic in_acc;
	logic out_load;
	logic [dmr_pkg::SCALE_W-1:0] diff;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign diff     = (target_scale > source_scale) ? (target_scale - source_scale)
	                                                : (source_scale - target_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			up_q     <= 1'b0;
			dig_q    <= '0;
			idx_q    <= '0;
			carry_q  <= '0;
			last_q   <= '0;
			sticky_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						up_q     <= (target_scale > source_scale);
						dig_q    <= diff;
						idx_q    <= '0;
						carry_q  <= '0;
						last_q   <= '0;
						sticky_q <= 1'b0;
						ovf_q    <= 1'b0;
						state_q  <= (diff == '0) ? S_FIN : S_RUN;
					end
				end
				S_RUN: begin
					idx_q   <= idx_q + IDX_W'(1);
					carry_q <= up_q ? mac[MW-1:HW] : div_r;
					if (last_step) begin
						idx_q   <= '0;
						carry_q <= '0;
						dig_q   <= dig_q - dmr_pkg::SCALE_W'(1);
						if (up_q) begin
							// carry out of the top chunk is lost
							if (mac[MW-1:HW] != '0) begin
								ovf_q <= 1'b1;
							end
							if (dig_q == dmr_pkg::SCALE_W'(1)) begin
								state_q <= S_FIN;
							end
						end else begin
							last_q   <= div_r;
							sticky_q <= sticky_n;
							if (dig_q == dmr_pkg::SCALE_W'(1)) begin
								if (rnd_up) begin
									carry_q <= dmr_pkg::ONE;
									state_q <= S_RND;
								end else begin
									state_q <= S_FIN;
								end
							end
						end
					end
				end
				S_RND: begin
					idx_q   <= idx_q + IDX_W'(1);
					carry_q <= mac[MW-1:HW];
					if (last_step) begin
						idx_q   <= '0;
						carry_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working mantissa: multiply and increment passes rotate down (chunk 0 out,
	// result in at the top); divide passes rotate up (top out, quotient in at 0).
	// After a full pass every chunk is back at its place.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < NH; i++) begin
				m_q[i] <= load_h[i];
			end
		end else if ((state_q == S_RND) || ((state_q == S_RUN) && up_q)) begin
			for (int i = 0; i < NH - 1; i++) begin
				m_q[i] <= m_q[i+1];
			end
			m_q[NH-1] <= mac[HW-1:0];
		end else if (state_q == S_RUN) begin
			for (int i = 1; i < NH; i++) begin
				m_q[i] <= m_q[i-1];
			end
			m_q[0] <= div_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dst_q  <= target_scale;
			sign_q <= sign_in;
		end
	end

	// ------------------------------------------------------------------------
	// Output register: hold the result beat while the next item is worked on.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar w = 0; w < IW; w++) begin : g_res
		if (w < MANT_WORDS) begin : g_live
			always_ff @(posedge clk) begin
				if (out_load) begin
					res_q[w] <= {m_q[2*w+1], m_q[2*w]};
				end
			end
		end else begin : g_dead
			assign res_q[w] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_scale_q <= dst_q;
			res_sign_q  <= sign_q;
			res_ovf_q   <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign res_word_0   = res_q[0];
	assign res_word_1   = res_q[1];
	assign res_word_2   = res_q[2];
	assign res_word_3   = res_q[3];
	assign res_word_4   = res_q[4];
	assign res_word_5   = res_q[5];
	assign res_word_6   = res_q[6];
	assign result_scale = res_scale_q;
	assign sign_out     = res_sign_q;
	assign overflow     = res_ovf_q;

`ifndef SYNTHESIS
	// divide correction leaves a true decimal remainder
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && !up_q) |-> (div_r < dmr_pkg::TEN))
		else $error("divide-by-ten remainder out of range");

	// multiply carry digit stays below ten
	a_mul_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && up_q) |-> (mac[MW-1:HW] < dmr_pkg::TEN))
		else $error("multiply-by-ten carry out of range");

	// rounding increment never carries out of the mantissa
	a_rnd_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND && last_step) |-> (mac[MW-1:HW] == '0))
		else $error("rounding increment carried out of the top chunk");

	// an accepted beat always starts work
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("input beat accepted without starting work");
`endif

endmodule : decimal_mantissa_rescale
`default_nettype wire
